[sv/sxc_pkg.sv]
`default_nettype none
package sxc_pkg;

	localparam int SECTOR_BYTES = 512;
	localparam logic [15:0] VRAM_LO = 16'h8000;
	localparam logic [15:0] VRAM_HI = 16'h87CF;
	localparam int BOOT_LEN = 15;

	typedef enum logic [2:0] {
		HOP_EXEC  = 3'd0,
		HOP_MWR   = 3'd1,
		HOP_MRD   = 3'd2,
		HOP_DWR   = 3'd3,
		HOP_DRD   = 3'd4
	} host_op_t;

	localparam logic [3:0] OP_NOP  = 4'h0;
	localparam logic [3:0] OP_MOV  = 4'h1;
	localparam logic [3:0] OP_MOVI = 4'h2;
	localparam logic [3:0] OP_ADD  = 4'h3;
	localparam logic [3:0] OP_SUB  = 4'h4;
	localparam logic [3:0] OP_MUL  = 4'h5;
	localparam logic [3:0] OP_DIV  = 4'h6;
	localparam logic [3:0] OP_OUT  = 4'h7;
	localparam logic [3:0] OP_JE   = 4'h8;
	localparam logic [3:0] OP_JNE  = 4'h9;
	localparam logic [3:0] OP_PEEK = 4'hA;
	localparam logic [3:0] OP_POKE = 4'hB;
	localparam logic [3:0] OP_LOAD = 4'hC;
	localparam logic [3:0] OP_SAVE = 4'hD;
	localparam logic [3:0] OP_POP  = 4'hE;
	localparam logic [3:0] OP_PUSH = 4'hF;

	localparam logic [3:0] REG_SP = 4'd14;
	localparam logic [3:0] REG_PC = 4'd15;

	typedef struct packed {
		logic [2:0]  opcode;
		logic [20:0] host_addr;
		logic [7:0]  host_data;
	} step_t;

	typedef struct packed {
		logic [7:0]  read_data;
		logic [15:0] pc;
		logic        halted;
		logic        out_valid;
		logic [1:0]  out_port;
		logic [15:0] out_data;
		logic        vram_touched;
	} result_t;

	function automatic logic [7:0] boot_byte(input logic [3:0] i);
		logic [7:0] b;
		begin
			unique case (i)
				4'd0: b = 8'h2E;
				4'd1: b = 8'hAF;
				4'd2: b = 8'hFF;
				4'd3: b = 8'h20;
				4'd6: b = 8'h21;
				4'd7: b = 8'h02;
				4'd9: b = 8'hC0;
				4'd10: b = 8'h10;
				4'd12: b = 8'h2F;
				4'd13: b = 8'h02;
				default: b = 8'h00;
			endcase
			return b;
		end
	endfunction

	function automatic logic in_vram(input logic [15:0] a);
		return (a >= VRAM_LO) && (a <= VRAM_HI);
	endfunction

endpackage
`default_nettype wire

[sv/sxc_stream_if.sv]
`default_nettype none
interface sxc_stream_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[sv/sxc_ram.sv]
`default_nettype none
module sxc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

[sv/sixteen_op_register_cpu_core_top.sv]
`default_nettype none
// Multicycle 16-bit core with sixteen registers, 64 KiB memory and a sector disk.
// Each step item yields one result item; the core takes the next item only once the
// current one has finished. An execute item while halted goes straight to the output.
// Other execute items make three fetch reads through the single memory read port,
// then register reads one a cycle; mul and a nonzero divide then run through the
// shared shift-add unit, and load or save take q = sector / DISK_SECTORS subtractions
// for the sector modulo (at most 22 with 2880 sectors) and then copy the sector byte
// by byte, each byte in an address, a read and a write step. The result sits in an
// output register; while it waits, the next item can finish into the sequencer's
// last state and is then held there until the output register frees.
// After reset a clearing pass writes the boot ROM and zeros into all 65536 memory
// bytes and then zeros all DISK_SECTORS*512 disk bytes, while no item is taken.
module sixteen_op_register_cpu_core_top
	import sxc_pkg::*;
#(
	parameter int DISK_SECTORS = 2880
) (
	input wire logic clk,
	input wire logic arst_n,
	sxc_stream_if.sink   step,
	sxc_stream_if.source result
);
	localparam int DISK_BYTES = DISK_SECTORS * SECTOR_BYTES;
	localparam int DAW = $clog2(DISK_BYTES);
	localparam int CW = (DAW > 16) ? DAW : 16;

	typedef enum logic [16:0] {
		S_CLRM  = 17'h00001,
		S_CLRD  = 17'h00002,
		S_IDLE  = 17'h00004,
		S_HOST  = 17'h00008,
		S_F0    = 17'h00010,
		S_F1    = 17'h00020,
		S_F2    = 17'h00040,
		S_RA    = 17'h00080,
		S_RB    = 17'h00100,
		S_RC    = 17'h00200,
		S_EXEC  = 17'h00400,
		S_ITER  = 17'h00800,
		S_MEM   = 17'h01000,
		S_MOD   = 17'h02000,
		S_COPY  = 17'h04000,
		S_WB    = 17'h08000,
		S_OUT   = 17'h10000
	} state_t;

	state_t state_q;
	step_t   in_q;
	result_t wres_q;
	result_t res_q;
	logic    res_valid_q;

	logic [15:0] regs_q [16];
	logic        halt_q;
	logic [7:0]  b1_q, b2_q, b3_q;
	logic [15:0] va_q, vb_q, vc_q;
	logic [CW:0] clr_q;
	logic [4:0]  it_q;
	logic [31:0] acc_q;
	logic [15:0] div_q;
	logic [10:0] cnt_q;
	logic [1:0]  sub_q;
	logic [DAW-1:0] dbase_q;
	logic [15:0] maddr_q;
	logic [7:0]  tmp_q;

	// memory and disk ports
	logic        m_we, d_we;
	logic [15:0] m_wa, m_ra;
	logic [7:0]  m_wd, m_rd, d_wd, d_rd;
	logic [DAW-1:0] d_wa, d_ra;

	sxc_ram #(.WIDTH(8), .DEPTH(65536)) u_mem (
		.clk(clk), .we(m_we), .waddr(m_wa), .wdata(m_wd), .raddr(m_ra), .rdata(m_rd)
	);
	sxc_ram #(.WIDTH(8), .DEPTH(DISK_BYTES)) u_disk (
		.clk(clk), .we(d_we), .waddr(d_wa), .wdata(d_wd), .raddr(d_ra), .rdata(d_rd)
	);

	logic [3:0] op, ra, rb, rc;
	assign op = b1_q[7:4];
	assign ra = b1_q[3:0];
	assign rb = b2_q[7:4];
	assign rc = b2_q[3:0];

	logic [15:0] pc;
	assign pc = regs_q[REG_PC];

	logic disk_ok;
	assign disk_ok = ({11'd0, in_q.host_addr} < 32'(DISK_BYTES));

	// finished item moves into the output register
	logic load_res;
	assign load_res = (state_q == S_OUT) && (!res_valid_q || result.ready);

	assign step.ready = (state_q == S_IDLE);
	assign result.valid = res_valid_q;
	assign result.data = res_q;

	// shift-subtract trial step of the restoring divide
	logic [16:0] dtrial;
	assign dtrial = {acc_q[15:0], div_q[15]} - {1'b0, vb_q};

	// port wiring
	always_comb begin
		m_we = 1'b0;
		m_wa = maddr_q;
		m_wd = tmp_q;
		m_ra = maddr_q;
		d_we = 1'b0;
		d_wa = DAW'(in_q.host_addr);
		d_wd = in_q.host_data;
		d_ra = DAW'(in_q.host_addr);
		unique case (state_q)
			S_CLRM: begin
				m_we = 1'b1;
				m_wa = clr_q[15:0];
				m_wd = (clr_q < (CW+1)'(BOOT_LEN)) ? boot_byte(clr_q[3:0]) : 8'h00;
			end
			S_CLRD: begin
				d_we = 1'b1;
				d_wa = clr_q[DAW-1:0];
				d_wd = 8'h00;
			end
			S_HOST: begin
				if (sub_q == 2'd0) begin
					m_we = (in_q.opcode == HOP_MWR);
					m_wa = in_q.host_addr[15:0];
					m_wd = in_q.host_data;
					m_ra = in_q.host_addr[15:0];
					d_we = (in_q.opcode == HOP_DWR) && disk_ok;
				end
			end
			S_MEM: begin
				m_we = (op == OP_POKE) || (op == OP_PUSH);
			end
			S_COPY: begin
				d_ra = dbase_q + DAW'(cnt_q[9:0]);
				d_wa = d_ra;
				d_wd = m_rd;
				if (sub_q == 2'd2) begin
					m_we = (op == OP_LOAD);
					m_wd = d_rd;
					d_we = (op == OP_SAVE);
				end
			end
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (load_res) begin
			res_valid_q <= 1'b1;
			res_q <= '{read_data: wres_q.read_data, pc: pc, halted: halt_q,
				out_valid: wres_q.out_valid, out_port: wres_q.out_port,
				out_data: wres_q.out_data, vram_touched: wres_q.vram_touched};
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// main sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLRM;
			clr_q <= '0;
			halt_q <= 1'b0;
			for (int i = 0; i < 16; i++) regs_q[i] <= '0;
			sub_q <= '0;
		end else begin
			unique case (state_q)
				S_CLRM: begin
					if (clr_q == (CW+1)'(65535)) begin
						clr_q <= '0;
						state_q <= S_CLRD;
					end else begin
						clr_q <= clr_q + 1'b1;
					end
				end
				S_CLRD: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == (CW+1)'(DISK_BYTES-1)) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (step.valid) begin
						in_q <= step.data;
						wres_q <= '0;
						sub_q <= '0;
						maddr_q <= pc;
						if (step.data.opcode == HOP_EXEC) begin
							state_q <= halt_q ? S_OUT : S_F0;
						end else begin
							state_q <= S_HOST;
						end
					end
				end
				S_HOST: begin
					sub_q <= sub_q + 1'b1;
					if (sub_q == 2'd1) begin
						if (in_q.opcode == HOP_MRD) wres_q.read_data <= m_rd;
						if (in_q.opcode == HOP_DRD && disk_ok) wres_q.read_data <= d_rd;
						state_q <= S_OUT;
					end
				end
				// three fetch reads, one address a cycle, each byte registered by the read port and taken in the next state
				S_F0: begin
					maddr_q <= maddr_q + 16'd1;
					state_q <= S_F1;
				end
				S_F1: begin
					b1_q <= m_rd;
					maddr_q <= maddr_q + 16'd1;
					state_q <= S_F2;
				end
				S_F2: begin
					b2_q <= m_rd;
					state_q <= S_RA;
				end
				S_RA: begin
					b3_q <= m_rd;
					va_q <= regs_q[ra];
					state_q <= S_RB;
				end
				S_RB: begin
					vb_q <= regs_q[rb];
					state_q <= S_RC;
				end
				S_RC: begin
					vc_q <= regs_q[rc];
					state_q <= S_EXEC;
				end
				S_EXEC: begin
					sub_q <= '0;
					it_q <= '0;
					unique case (op)
						OP_NOP: begin
							regs_q[REG_PC] <= pc + 16'd1;
							state_q <= S_OUT;
						end
						OP_MOV: begin
							acc_q <= {16'd0, vb_q};
							state_q <= S_WB;
						end
						OP_MOVI: begin
							acc_q <= {16'd0, b2_q, b3_q};
							state_q <= S_WB;
						end
						OP_ADD: begin
							acc_q <= {16'd0, va_q + vb_q};
							state_q <= S_WB;
						end
						OP_SUB: begin
							acc_q <= {16'd0, va_q - vb_q};
							state_q <= S_WB;
						end
						OP_MUL, OP_DIV: begin
							acc_q <= '0;
							div_q <= va_q;
							if (op == OP_DIV && vb_q == 16'd0) begin
								halt_q <= 1'b1;
								state_q <= S_WB;
							end else begin
								state_q <= S_ITER;
							end
						end
						OP_OUT: begin
							if (va_q == 16'd1 || va_q == 16'd2) begin
								wres_q.out_valid <= 1'b1;
								wres_q.out_port <= va_q[1:0];
								wres_q.out_data <= vb_q;
							end
							state_q <= S_WB;
						end
						OP_JE, OP_JNE: state_q <= S_WB;
						OP_PEEK: begin
							maddr_q <= vb_q;
							state_q <= S_MEM;
						end
						OP_POKE: begin
							maddr_q <= vb_q;
							tmp_q <= (vc_q == 16'd1) ? va_q[7:0] : va_q[15:8];
							state_q <= S_MEM;
						end
						OP_LOAD, OP_SAVE: begin
							acc_q <= {16'd0, va_q};
							state_q <= S_MOD;
						end
						OP_POP: begin
							maddr_q <= regs_q[REG_SP];
							state_q <= S_MEM;
						end
						default: begin
							maddr_q <= regs_q[REG_SP] - 16'd2;
							tmp_q <= va_q[15:8];
							regs_q[REG_SP] <= regs_q[REG_SP] - 16'd2;
							state_q <= S_MEM;
						end
					endcase
				end
				// shift-add multiply or restoring divide, one bit a cycle
				S_ITER: begin
					it_q <= it_q + 1'b1;
					if (op == OP_MUL) begin
						acc_q <= {acc_q[30:0], 1'b0} + (div_q[15] ? {16'd0, vb_q} : 32'd0);
						div_q <= {div_q[14:0], 1'b0};
					end else begin
						div_q <= {div_q[14:0], ~dtrial[16]};
						acc_q[15:0] <= dtrial[16] ? {acc_q[14:0], div_q[15]} : dtrial[15:0];
					end
					if (it_q == 5'd15) state_q <= S_WB;
				end
				// memory side of peek, poke, pop, push
				S_MEM: begin
					sub_q <= sub_q + 1'b1;
					if (op == OP_POKE || op == OP_PUSH) begin
						if (op == OP_POKE && in_vram(maddr_q)) wres_q.vram_touched <= 1'b1;
						maddr_q <= maddr_q + 16'd1;
						tmp_q <= va_q[7:0];
						if (sub_q == 2'd1 || (op == OP_POKE && vc_q == 16'd1)) begin
							state_q <= S_WB;
						end
					end else begin
						if (sub_q == 2'd0) maddr_q <= maddr_q + 16'd1;
						if (sub_q == 2'd1) tmp_q <= m_rd;
						if (sub_q == 2'd2) begin
							acc_q <= (op == OP_PEEK && vc_q == 16'd1)
								? {24'd0, tmp_q} : {16'd0, tmp_q, m_rd};
							state_q <= S_WB;
						end
					end
				end
				// sector index modulo by repeated subtraction of the sector count
				S_MOD: begin
					it_q <= it_q + 1'b1;
					if (acc_q[15:0] >= 16'(DISK_SECTORS) && 32'(DISK_SECTORS) < 32'h10000) begin
						acc_q[15:0] <= acc_q[15:0] - 16'(DISK_SECTORS);
					end else begin
						dbase_q <= DAW'({acc_q[15:0], 9'd0});
						maddr_q <= vb_q;
						cnt_q <= '0;
						sub_q <= '0;
						state_q <= S_COPY;
					end
				end
				// byte copy: address, read, write
				S_COPY: begin
					sub_q <= (sub_q == 2'd2) ? 2'd0 : sub_q + 1'b1;
					if (sub_q == 2'd2) begin
						cnt_q <= cnt_q + 1'b1;
						maddr_q <= maddr_q + 16'd1;
						if (cnt_q == 11'(SECTOR_BYTES-1)) state_q <= S_WB;
					end
				end
				S_WB: begin
					state_q <= S_OUT;
					priority case (op)
						OP_MOV, OP_MOVI, OP_POP: begin
							// pop into the stack pointer still gets the +2
							if (op == OP_POP && ra == REG_SP) begin
								regs_q[REG_SP] <= acc_q[15:0] + 16'd2;
							end else begin
								regs_q[ra] <= acc_q[15:0];
								if (op == OP_POP) regs_q[REG_SP] <= regs_q[REG_SP] + 16'd2;
							end
							if (ra != REG_PC) regs_q[REG_PC] <= pc + 16'd3;
						end
						OP_ADD, OP_SUB, OP_MUL, OP_PEEK: begin
							if (ra == REG_PC) begin
								regs_q[REG_PC] <= acc_q[15:0] + 16'd3;
							end else begin
								regs_q[ra] <= acc_q[15:0];
								regs_q[REG_PC] <= pc + 16'd3;
							end
						end
						OP_DIV: begin
							if (vb_q == 16'd0) begin
								regs_q[REG_PC] <= pc + 16'd3;
							end else if (ra == REG_PC) begin
								regs_q[REG_PC] <= div_q + 16'd3;
							end else begin
								regs_q[ra] <= div_q;
								regs_q[REG_PC] <= pc + 16'd3;
							end
						end
						OP_JE, OP_JNE: begin
							if ((va_q == vb_q) == (op == OP_JE)) regs_q[REG_PC] <= vc_q;
							else regs_q[REG_PC] <= pc + 16'd3;
						end
						default: regs_q[REG_PC] <= pc + 16'd3;
					endcase
				end
				S_OUT: begin
					if (load_res) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

[sv/sxc_checker.sv]
`default_nettype none
module sxc_checker
	import sxc_pkg::*;
(
	input wire logic    clk,
	input wire logic    arst_n,
	input wire logic    in_valid,
	input wire logic    in_ready,
	input wire logic    out_valid,
	input wire logic    out_ready,
	input wire result_t out_data
);
	// a held result keeps its value
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// not ready in the cycle after an item is taken
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("ready right after accept");

	// out fields are zero unless an out was reported
	a_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.out_valid |-> out_data.out_port == 2'd0 && out_data.out_data == 16'd0)
		else $error("stray out data");

	// halt never clears once reported
	a_halt: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.halted |=> !out_valid || out_data.halted)
		else $error("halt cleared");
endmodule

bind sixteen_op_register_cpu_core_top sxc_checker u_sxc_checker (
	.clk(clk), .arst_n(arst_n),
	.in_valid(step.valid), .in_ready(step.ready),
	.out_valid(result.valid), .out_ready(result.ready), .out_data(result.data)
);
`default_nettype wire

[test/tb_sixteen_op_register_cpu_core_top.sv]
`default_nettype none
module tb_sixteen_op_register_cpu_core_top;
	import sxc_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	// small disk keeps the clearing pass after reset short
	localparam int NSECT = 4;
	localparam int DISK_BYTES = NSECT * SECTOR_BYTES;
	localparam int LIMIT = 2000000;
	localparam int N_RANDOM = 400;

	typedef struct packed {
		step_t   item;
		logic    typed;
		result_t want;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	sxc_stream_if #(.T(step_t))   step_ch ();
	sxc_stream_if #(.T(result_t)) result_ch ();

	sixteen_op_register_cpu_core_top #(.DISK_SECTORS(NSECT)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.step(step_ch),
		.result(result_ch)
	);

	always #4 clk = ~clk;

	// shadow copy of the core state
	logic [15:0] regs [16];
	logic [7:0]  mem_img [65536];
	logic [7:0]  disk_img [DISK_BYTES];
	logic        halt_q;

	// expected results, written at send time and read in order
	result_t     exp_tab [2048];
	logic [10:0] exp_wr = '0;
	logic [10:0] exp_rd = '0;
	row_t        dir_tab [32];
	int          n_rows = 0;
	int      n_err = 0;
	int      n_sent = 0;
	int      n_got = 0;
	int      cyc = 0;
	int      hold = 0;

	function automatic logic vram_hit(input logic [15:0] a);
		return a >= 16'h8000 && a <= 16'h87CF;
	endfunction

	// one step of the core: updates the shadow state, returns the result item
	function automatic result_t cpu_predict(input step_t s);
		result_t     o;
		logic [15:0] pc, a, v, imm;
		logic [7:0]  b1, b2, b3;
		logic [3:0]  op, ra, rb, rc;
		logic [31:0] prod;
		logic        jumped;
		int          base;
		o = '0;
		case (s.opcode)
			HOP_EXEC: begin
				if (!halt_q) begin
					pc = regs[REG_PC];
					b1 = mem_img[pc];
					b2 = mem_img[16'(pc + 16'd1)];
					b3 = mem_img[16'(pc + 16'd2)];
					op = b1[7:4];
					ra = b1[3:0];
					rb = b2[7:4];
					rc = b2[3:0];
					imm = {b2, b3};
					jumped = 1'b0;
					case (op)
						OP_MOV: begin
							regs[ra] = regs[rb];
							jumped = (ra == REG_PC);
						end
						OP_MOVI: begin
							regs[ra] = imm;
							jumped = (ra == REG_PC);
						end
						OP_ADD: regs[ra] = regs[ra] + regs[rb];
						OP_SUB: regs[ra] = regs[ra] - regs[rb];
						OP_MUL: begin
							prod = regs[ra] * regs[rb];
							regs[ra] = prod[15:0];
						end
						OP_DIV: begin
							if (regs[rb] != 16'd0) regs[ra] = regs[ra] / regs[rb];
							else halt_q = 1'b1;
						end
						OP_OUT: begin
							if (regs[ra] == 16'd1 || regs[ra] == 16'd2) begin
								o.out_valid = 1'b1;
								o.out_port = regs[ra][1:0];
								o.out_data = regs[rb];
							end
						end
						OP_JE: begin
							if (regs[ra] == regs[rb]) begin
								regs[REG_PC] = regs[rc];
								jumped = 1'b1;
							end
						end
						OP_JNE: begin
							if (regs[ra] != regs[rb]) begin
								regs[REG_PC] = regs[rc];
								jumped = 1'b1;
							end
						end
						OP_PEEK: begin
							a = regs[rb];
							if (regs[rc] == 16'd1) regs[ra] = {8'h00, mem_img[a]};
							else regs[ra] = {mem_img[a], mem_img[16'(a + 16'd1)]};
						end
						OP_POKE: begin
							v = regs[ra];
							a = regs[rb];
							if (vram_hit(a)) o.vram_touched = 1'b1;
							if (regs[rc] == 16'd1) begin
								mem_img[a] = v[7:0];
							end else begin
								mem_img[a] = v[15:8];
								mem_img[16'(a + 16'd1)] = v[7:0];
								if (vram_hit(16'(a + 16'd1))) o.vram_touched = 1'b1;
							end
						end
						OP_LOAD: begin
							base = (int'(regs[ra]) % NSECT) * SECTOR_BYTES;
							a = regs[rb];
							for (int i = 0; i < SECTOR_BYTES; i++)
								mem_img[16'(a + i)] = disk_img[base + i];
						end
						OP_SAVE: begin
							base = (int'(regs[ra]) % NSECT) * SECTOR_BYTES;
							a = regs[rb];
							for (int i = 0; i < SECTOR_BYTES; i++)
								disk_img[base + i] = mem_img[16'(a + i)];
						end
						OP_POP: begin
							a = regs[REG_SP];
							v = {mem_img[a], mem_img[16'(a + 16'd1)]};
							regs[ra] = v;
							regs[REG_SP] = regs[REG_SP] + 16'd2;
							jumped = (ra == REG_PC);
						end
						OP_PUSH: begin
							v = regs[ra];
							regs[REG_SP] = regs[REG_SP] - 16'd2;
							a = regs[REG_SP];
							mem_img[a] = v[15:8];
							mem_img[16'(a + 16'd1)] = v[7:0];
						end
						default: ;
					endcase
					// nop advances by one, everything else by three unless it jumped
					if (op == OP_NOP) regs[REG_PC] = regs[REG_PC] + 16'd1;
					else if (!jumped) regs[REG_PC] = regs[REG_PC] + 16'd3;
				end
			end
			HOP_MWR: mem_img[s.host_addr[15:0]] = s.host_data;
			HOP_MRD: o.read_data = mem_img[s.host_addr[15:0]];
			HOP_DWR: if (s.host_addr < DISK_BYTES) disk_img[s.host_addr] = s.host_data;
			HOP_DRD: if (s.host_addr < DISK_BYTES) o.read_data = disk_img[s.host_addr];
			default: ;
		endcase
		o.pc = regs[REG_PC];
		o.halted = halt_q;
		return o;
	endfunction

	// idle-free stretches come and go with the item count
	function automatic int draw_gap(input int n);
		return ((n / 60) % 3 == 2) ? 0 : $urandom_range(0, 12);
	endfunction

	// offer one item, wait for it to be taken
	task automatic send_item(input step_t s, input logic typed, input result_t want);
		result_t p;
		int gap;
		p = cpu_predict(s);
		exp_tab[exp_wr] = typed ? want : p;
		exp_wr = exp_wr + 11'd1;
		gap = draw_gap(n_sent);
		if (gap > 0) begin
			step_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		step_ch.valid <= 1'b1;
		step_ch.data <= s;
		do @(posedge clk); while (!step_ch.ready);
		n_sent++;
	endtask

	task automatic add_row(input logic [2:0] opc, input logic [20:0] addr, input logic [7:0] d,
			input logic typed, input result_t want);
		row_t r;
		r.item = '{opcode: opc, host_addr: addr, host_data: d};
		r.typed = typed;
		r.want = want;
		dir_tab[n_rows] = r;
		n_rows++;
	endtask

	// cycle limit
	always @(posedge clk) begin
		cyc++;
		if (cyc > LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// result side: random stalls, one long hold-off to back the core up
	initial begin
		result_t e, g;
		result_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (result_ch.valid && result_ch.ready) begin
				g = result_ch.data;
				if (exp_rd == exp_wr) begin
					$display("%0t: unexpected result item %h", $time, g);
					n_err++;
				end else begin
					e = exp_tab[exp_rd];
					exp_rd = exp_rd + 11'd1;
					if (g.read_data !== e.read_data) begin
						$display("%0t: read_data exp %h got %h", $time, e.read_data, g.read_data);
						n_err++;
					end
					if (g.pc !== e.pc) begin
						$display("%0t: pc exp %h got %h", $time, e.pc, g.pc);
						n_err++;
					end
					if (g.halted !== e.halted) begin
						$display("%0t: halted exp %b got %b", $time, e.halted, g.halted);
						n_err++;
					end
					if (g.out_valid !== e.out_valid) begin
						$display("%0t: out_valid exp %b got %b", $time, e.out_valid, g.out_valid);
						n_err++;
					end
					if (g.out_port !== e.out_port) begin
						$display("%0t: out_port exp %h got %h", $time, e.out_port, g.out_port);
						n_err++;
					end
					if (g.out_data !== e.out_data) begin
						$display("%0t: out_data exp %h got %h", $time, e.out_data, g.out_data);
						n_err++;
					end
					if (g.vram_touched !== e.vram_touched) begin
						$display("%0t: vram_touched exp %b got %b", $time, e.vram_touched,
							g.vram_touched);
						n_err++;
					end
				end
				n_got++;
				hold = (n_got == 150) ? 400 : draw_gap(n_got);
				if (hold > 0) result_ch.ready <= 1'b0;
			end else if (hold > 0) begin
				hold--;
				if (hold == 0) result_ch.ready <= 1'b1;
			end else begin
				result_ch.ready <= 1'b1;
			end
		end
	end

	// stimulus
	initial begin
		step_t       s;
		result_t     z;
		logic [15:0] pc, imm;
		logic [3:0]  op, ra, rb, rc;
		logic [7:0]  b1, b2, b3;
		step_ch.valid <= 1'b0;
		step_ch.data <= '0;
		for (int i = 0; i < 16; i++) regs[i] = '0;
		for (int i = 0; i < 65536; i++) mem_img[i] = 8'h00;
		for (int i = 0; i < BOOT_LEN; i++) mem_img[i] = boot_byte(4'(i));
		for (int i = 0; i < DISK_BYTES; i++) disk_img[i] = 8'h00;
		halt_q = 1'b0;
		z = '0;

		// directed rows: boot bytes, address extremes, unused opcodes, boot run
		add_row(HOP_MRD, 21'd0, 8'h00, 1'b1, '{8'h2E, 16'h0000, 1'b0, 1'b0, 2'd0, 16'h0, 1'b0});
		add_row(HOP_DRD, 21'h1FFFFF, 8'hFF, 1'b1, z);
		add_row(HOP_DWR, 21'h1FFFFF, 8'hFF, 1'b1, z);
		add_row(HOP_DRD, 21'(DISK_BYTES), 8'h00, 1'b1, z);
		add_row(HOP_DRD, 21'(DISK_BYTES - 1), 8'h00, 1'b1, z);
		add_row(3'd5, 21'h1FFFFF, 8'hFF, 1'b1, z);
		add_row(3'd6, 21'h000000, 8'h00, 1'b1, z);
		add_row(3'd7, 21'h155555, 8'hAA, 1'b1, z);
		add_row(HOP_MWR, 21'h1FFFFF, 8'hA5, 1'b1, z);
		add_row(HOP_MRD, 21'h00FFFF, 8'h00, 1'b1, '{8'hA5, 16'h0, 1'b0, 1'b0, 2'd0, 16'h0, 1'b0});
		add_row(HOP_DWR, 21'd5, 8'h5A, 1'b1, z);
		add_row(HOP_DWR, 21'(DISK_BYTES - 1), 8'hFF, 1'b0, z);
		add_row(HOP_DRD, 21'(DISK_BYTES - 1), 8'h00, 1'b0, z);
		add_row(HOP_EXEC, 21'd0, 8'h00, 1'b1, '{8'h00, 16'h0003, 1'b0, 1'b0, 2'd0, 16'h0, 1'b0});
		add_row(HOP_EXEC, 21'd0, 8'h00, 1'b0, z);
		add_row(HOP_EXEC, 21'd0, 8'h00, 1'b0, z);
		add_row(HOP_EXEC, 21'd0, 8'h00, 1'b0, z);
		add_row(HOP_EXEC, 21'd0, 8'h00, 1'b0, z);
		add_row(HOP_MRD, 21'h000205, 8'h00, 1'b1, '{8'h5A, 16'h0200, 1'b0, 1'b0, 2'd0, 16'h0, 1'b0});
		add_row(HOP_EXEC, 21'd0, 8'h00, 1'b0, z);

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < n_rows; i++)
			send_item(dir_tab[i].item, dir_tab[i].typed, dir_tab[i].want);

		// random part: mostly an instruction placed at pc and then executed
		while (n_sent < N_RANDOM + n_rows) begin
			if ($urandom_range(0, 99) < 15) begin
				s.opcode = 3'($urandom_range(0, 7));
				s.host_addr = ($urandom_range(0, 1) == 1) ? 21'($urandom())
					: 21'($urandom_range(0, DISK_BYTES - 1));
				s.host_data = 8'($urandom());
				send_item(s, 1'b0, z);
			end else begin
				op = 4'($urandom_range(0, 15));
				ra = 4'($urandom());
				rb = 4'($urandom());
				rc = 4'($urandom());
				// sector copies are slow, keep them rare
				if ((op == OP_LOAD || op == OP_SAVE) && $urandom_range(0, 9) != 0) op = OP_MOVI;
				// a zero divide halts for good, so only near the end
				if (op == OP_DIV && regs[rb] == 16'd0 && n_sent < N_RANDOM) op = OP_ADD;
				b1 = {op, ra};
				b2 = {rb, rc};
				b3 = 8'($urandom());
				if (op == OP_MOVI) begin
					case ($urandom_range(0, 5))
						0: imm = 16'd1;
						1: imm = 16'd2;
						2: imm = 16'h8000 + 16'($urandom_range(0, 16'h7CF));
						3: imm = 16'hFFFF;
						4: imm = 16'h0000;
						default: imm = 16'($urandom());
					endcase
					{b2, b3} = imm;
				end
				pc = regs[REG_PC];
				send_item('{HOP_MWR, 21'(pc), b1}, 1'b0, z);
				send_item('{HOP_MWR, 21'(16'(pc + 16'd1)), b2}, 1'b0, z);
				send_item('{HOP_MWR, 21'(16'(pc + 16'd2)), b3}, 1'b0, z);
				send_item('{HOP_EXEC, 21'($urandom()), 8'($urandom())}, 1'b0, z);
			end
		end
		step_ch.valid <= 1'b0;

		while (exp_rd != exp_wr) @(posedge clk);
		repeat (50) @(posedge clk);
		if (n_err == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
`default_nettype wire
